// ----- hdl/rmq_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, sideband types and the output saturation function of the
// rotation matrix to quaternion pipeline. Depends on nothing.
package rmq_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int IN_W       = 18;
	localparam int OUT_W      = 18;
	localparam int N_IN       = 9;
	localparam int N_LANE     = 3;
	localparam int IN_DATA_W  = ((N_IN * IN_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((4 * OUT_W + 7) / 8) * 8;
	localparam int USER_W     = 3;

	localparam int TR_W   = IN_W + 2;
	localparam int ARG_W  = ((FRAC_BITS + 2 > IN_W + 2) ? FRAC_BITS + 2 : IN_W + 2) + 1;
	localparam int RW     = (ARG_W - 1 + FRAC_BITS + 1) / 2;
	localparam int SQ_W   = 2 * RW;
	localparam int REM_W  = RW + 2;
	localparam int NUM_W  = IN_W + 1;
	localparam int DW     = NUM_W + FRAC_BITS;

	localparam logic signed [ARG_W-1:0] ONE_ARG = ARG_W'(64'd1 << FRAC_BITS);

	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	typedef struct packed {
		logic [1:0]                    sel;
		logic                          invalid;
		logic [N_LANE-1:0]             neg;
		logic [N_LANE-1:0][NUM_W-1:0]  mag;
	} sq_side_t;

	typedef struct packed {
		logic [1:0]        sel;
		logic              invalid;
		logic [N_LANE-1:0] neg;
		logic [RW-1:0]     quarter;
	} div_side_t;

	function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [DW-1:0] mag);
		logic [DW-1:0] pos_lim;
		logic [DW-1:0] neg_lim;
		logic [OUT_W-1:0] res;
		pos_lim = DW'((64'd1 << (OUT_W - 1)) - 64'd1);
		neg_lim = DW'(64'd1 << (OUT_W - 1));
		if (!neg) begin
			res = (mag > pos_lim) ? pos_lim[OUT_W-1:0] : mag[OUT_W-1:0];
		end else begin
			res = (mag > neg_lim) ? neg_lim[OUT_W-1:0] : (~mag[OUT_W-1:0] + OUT_W'(1));
		end
		return res;
	endfunction

endpackage

// ----- hdl/rmq_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
// Depends on rmq_pkg for widths and the sideband type.
module rmq_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [rmq_pkg::SQ_W-1:0]     in_x,
	input  rmq_pkg::sq_side_t            in_side,
	output logic                         out_vld,
	output logic [rmq_pkg::RW-1:0]       out_root,
	output rmq_pkg::sq_side_t            out_side
);

	logic                          vld_s  [1:rmq_pkg::RW];
	logic [rmq_pkg::SQ_W-1:0]      x_s    [1:rmq_pkg::RW];
	logic [rmq_pkg::REM_W-1:0]     rem_s  [1:rmq_pkg::RW];
	logic [rmq_pkg::RW-1:0]        root_s [1:rmq_pkg::RW];
	rmq_pkg::sq_side_t             side_s [1:rmq_pkg::RW];

	for (genvar k = 0; k < rmq_pkg::RW; k++) begin : g_stage
		logic                      vld_c;
		logic [rmq_pkg::SQ_W-1:0]  x_c;
		logic [rmq_pkg::REM_W-1:0] rem_c;
		logic [rmq_pkg::RW-1:0]    root_c;
		rmq_pkg::sq_side_t         side_c;
		logic [rmq_pkg::REM_W-1:0] cur;
		logic [rmq_pkg::REM_W-1:0] trial;
		logic                      ge;

		if (k == 0) begin : g_first
			assign vld_c  = in_vld;
			assign x_c    = in_x;
			assign rem_c  = '0;
			assign root_c = '0;
			assign side_c = in_side;
		end else begin : g_next
			assign vld_c  = vld_s[k];
			assign x_c    = x_s[k];
			assign rem_c  = rem_s[k];
			assign root_c = root_s[k];
			assign side_c = side_s[k];
		end

		assign cur   = {rem_c[rmq_pkg::RW-1:0], x_c[rmq_pkg::SQ_W-1 -: 2]};
		assign trial = {root_c, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= {x_c[rmq_pkg::SQ_W-3:0], 2'b00};
				rem_s[k+1]  <= ge ? (cur - trial) : cur;
				root_s[k+1] <= {root_c[rmq_pkg::RW-2:0], ge};
				side_s[k+1] <= side_c;
			end
		end
	end

	assign out_vld  = vld_s[rmq_pkg::RW];
	assign out_root = root_s[rmq_pkg::RW];
	assign out_side = side_s[rmq_pkg::RW];

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[rmq_pkg::RW] |-> rem_s[rmq_pkg::RW] <= {1'b0, root_s[rmq_pkg::RW], 1'b0})
		else $error("square root remainder exceeds twice the root");
`endif

endmodule

// ----- hdl/rmq_div.sv -----
`timescale 1ns / 1ps
// Three pipelined restoring dividers sharing one divisor 2r, one quotient bit
// per register stage. Depends on rmq_pkg for widths and sideband types.
module rmq_div (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  logic                                           in_vld,
	input  logic [rmq_pkg::RW-1:0]                         in_root,
	input  rmq_pkg::sq_side_t                              in_side,
	output logic                                           out_vld,
	output logic [rmq_pkg::N_LANE-1:0][rmq_pkg::DW-1:0]    out_quo,
	output rmq_pkg::div_side_t                             out_side
);

	logic                                           vld_s  [1:rmq_pkg::DW];
	logic [rmq_pkg::RW:0]                           d_s    [1:rmq_pkg::DW];
	logic [rmq_pkg::N_LANE-1:0][rmq_pkg::DW-1:0]    dv_s   [1:rmq_pkg::DW];
	logic [rmq_pkg::N_LANE-1:0][rmq_pkg::REM_W-1:0] rem_s  [1:rmq_pkg::DW];
	logic [rmq_pkg::N_LANE-1:0][rmq_pkg::DW-1:0]    quo_s  [1:rmq_pkg::DW];
	rmq_pkg::div_side_t                             side_s [1:rmq_pkg::DW];

	rmq_pkg::div_side_t                             side0;
	logic [rmq_pkg::N_LANE-1:0][rmq_pkg::DW-1:0]    dv0;

	always_comb begin
		side0.sel     = in_side.sel;
		side0.invalid = in_side.invalid;
		side0.neg     = in_side.neg;
		side0.quarter = in_root >> 1;
		for (int l = 0; l < rmq_pkg::N_LANE; l++) begin
			dv0[l] = {in_side.mag[l], {rmq_pkg::FRAC_BITS{1'b0}}};
		end
	end

	for (genvar k = 0; k < rmq_pkg::DW; k++) begin : g_stage
		logic                                           vld_c;
		logic [rmq_pkg::RW:0]                           d_c;
		logic [rmq_pkg::N_LANE-1:0][rmq_pkg::DW-1:0]    dv_c;
		logic [rmq_pkg::N_LANE-1:0][rmq_pkg::REM_W-1:0] rem_c;
		logic [rmq_pkg::N_LANE-1:0][rmq_pkg::DW-1:0]    quo_c;
		rmq_pkg::div_side_t                             side_c;
		logic [rmq_pkg::N_LANE-1:0][rmq_pkg::REM_W-1:0] rem_n;
		logic [rmq_pkg::N_LANE-1:0][rmq_pkg::DW-1:0]    quo_n;

		if (k == 0) begin : g_first
			assign vld_c  = in_vld;
			assign d_c    = {in_root, 1'b0};
			assign dv_c   = dv0;
			assign rem_c  = '0;
			assign quo_c  = '0;
			assign side_c = side0;
		end else begin : g_next
			assign vld_c  = vld_s[k];
			assign d_c    = d_s[k];
			assign dv_c   = dv_s[k];
			assign rem_c  = rem_s[k];
			assign quo_c  = quo_s[k];
			assign side_c = side_s[k];
		end

		always_comb begin
			logic [rmq_pkg::REM_W-1:0] cur;
			logic                      ge;
			for (int l = 0; l < rmq_pkg::N_LANE; l++) begin
				cur      = {rem_c[l][rmq_pkg::RW:0], dv_c[l][rmq_pkg::DW-1]};
				ge       = cur >= {1'b0, d_c};
				rem_n[l] = ge ? (cur - {1'b0, d_c}) : cur;
				quo_n[l] = {quo_c[l][rmq_pkg::DW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1]    <= d_c;
				for (int l = 0; l < rmq_pkg::N_LANE; l++) begin
					dv_s[k+1][l] <= {dv_c[l][rmq_pkg::DW-2:0], 1'b0};
				end
				rem_s[k+1]  <= rem_n;
				quo_s[k+1]  <= quo_n;
				side_s[k+1] <= side_c;
			end
		end
	end

	assign out_vld  = vld_s[rmq_pkg::DW];
	assign out_quo  = quo_s[rmq_pkg::DW];
	assign out_side = side_s[rmq_pkg::DW];

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[rmq_pkg::DW] && !side_s[rmq_pkg::DW].invalid |->
		(rem_s[rmq_pkg::DW][0] < {1'b0, d_s[rmq_pkg::DW]}) &&
		(rem_s[rmq_pkg::DW][1] < {1'b0, d_s[rmq_pkg::DW]}) &&
		(rem_s[rmq_pkg::DW][2] < {1'b0, d_s[rmq_pkg::DW]}))
		else $error("divider remainder not below divisor");
`endif

endmodule

// ----- hdl/rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 1ps
// Two setup stages, one per root bit, one per quotient bit and the output register.
// Throughput is one matrix per cycle; a stall on the output freezes the whole pipe.
// Reset is asynchronous and active low and clears only the valid bits.
// Top level of the rotation matrix to quaternion pipeline.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0: m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill.
	input  logic [rmq_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Fields from bit 0: quat_w, quat_x, quat_y, quat_z.
	output logic [rmq_pkg::OUT_DATA_W-1:0]   m_tdata,
	// Fields from bit 0: branch_used (2 bits), invalid.
	output logic [rmq_pkg::USER_W-1:0]       m_tuser
);

	logic en;
	logic signed [rmq_pkg::IN_W-1:0] a [rmq_pkg::N_IN];

	logic                              vld_s1;
	logic                              tr_pos_s1, g0011_s1, g0022_s1, g1122_s1;
	logic signed [rmq_pkg::ARG_W-1:0]  arg0_s1, argx_s1, argy_s1, argz_s1;
	logic signed [rmq_pkg::NUM_W-1:0]  n21m12_s1, n02m20_s1, n10m01_s1;
	logic signed [rmq_pkg::NUM_W-1:0]  n01p10_s1, n02p20_s1, n12p21_s1;

	logic                              vld_s2;
	logic [rmq_pkg::SQ_W-1:0]          x_s2;
	rmq_pkg::sq_side_t                 side_s2;

	logic [1:0]                        sel_c;
	logic signed [rmq_pkg::ARG_W-1:0]  arg_c;
	logic                              inv_c;
	logic signed [rmq_pkg::NUM_W-1:0]  lane_c [rmq_pkg::N_LANE];
	rmq_pkg::sq_side_t                 side_c;

	logic                              sq_vld;
	logic [rmq_pkg::RW-1:0]            sq_root;
	rmq_pkg::sq_side_t                 sq_side;

	logic                                             dv_vld;
	logic [rmq_pkg::N_LANE-1:0][rmq_pkg::DW-1:0]      dv_quo;
	rmq_pkg::div_side_t                               dv_side;

	logic [rmq_pkg::N_LANE-1:0][rmq_pkg::OUT_W-1:0]   lane_o;
	logic [rmq_pkg::OUT_W-1:0]                        quar_o;
	logic [rmq_pkg::OUT_W-1:0]                        qw, qx, qy, qz;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	for (genvar i = 0; i < rmq_pkg::N_IN; i++) begin : g_unpack
		assign a[i] = signed'(s_tdata[i*rmq_pkg::IN_W +: rmq_pkg::IN_W]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tr_pos_s1 <= (rmq_pkg::TR_W'(a[0]) + rmq_pkg::TR_W'(a[4]) +
			              rmq_pkg::TR_W'(a[8])) > 0;
			g0011_s1  <= a[0] > a[4];
			g0022_s1  <= a[0] > a[8];
			g1122_s1  <= a[4] > a[8];
			arg0_s1   <= rmq_pkg::ONE_ARG + rmq_pkg::ARG_W'(a[0]) +
			             rmq_pkg::ARG_W'(a[4]) + rmq_pkg::ARG_W'(a[8]);
			argx_s1   <= rmq_pkg::ONE_ARG + rmq_pkg::ARG_W'(a[0]) -
			             rmq_pkg::ARG_W'(a[4]) - rmq_pkg::ARG_W'(a[8]);
			argy_s1   <= rmq_pkg::ONE_ARG + rmq_pkg::ARG_W'(a[4]) -
			             rmq_pkg::ARG_W'(a[0]) - rmq_pkg::ARG_W'(a[8]);
			argz_s1   <= rmq_pkg::ONE_ARG + rmq_pkg::ARG_W'(a[8]) -
			             rmq_pkg::ARG_W'(a[0]) - rmq_pkg::ARG_W'(a[4]);
			n21m12_s1 <= rmq_pkg::NUM_W'(a[7]) - rmq_pkg::NUM_W'(a[5]);
			n02m20_s1 <= rmq_pkg::NUM_W'(a[2]) - rmq_pkg::NUM_W'(a[6]);
			n10m01_s1 <= rmq_pkg::NUM_W'(a[3]) - rmq_pkg::NUM_W'(a[1]);
			n01p10_s1 <= rmq_pkg::NUM_W'(a[1]) + rmq_pkg::NUM_W'(a[3]);
			n02p20_s1 <= rmq_pkg::NUM_W'(a[2]) + rmq_pkg::NUM_W'(a[6]);
			n12p21_s1 <= rmq_pkg::NUM_W'(a[5]) + rmq_pkg::NUM_W'(a[7]);
		end
	end

	always_comb begin
		if (tr_pos_s1) begin
			sel_c = rmq_pkg::BR_TRACE;
		end else if (g0011_s1 && g0022_s1) begin
			sel_c = rmq_pkg::BR_X;
		end else if (g1122_s1) begin
			sel_c = rmq_pkg::BR_Y;
		end else begin
			sel_c = rmq_pkg::BR_Z;
		end
		case (sel_c)
			rmq_pkg::BR_TRACE: begin
				arg_c     = arg0_s1;
				lane_c[0] = n21m12_s1;
				lane_c[1] = n02m20_s1;
				lane_c[2] = n10m01_s1;
			end
			rmq_pkg::BR_X: begin
				arg_c     = argx_s1;
				lane_c[0] = n21m12_s1;
				lane_c[1] = n01p10_s1;
				lane_c[2] = n02p20_s1;
			end
			rmq_pkg::BR_Y: begin
				arg_c     = argy_s1;
				lane_c[0] = n02m20_s1;
				lane_c[1] = n01p10_s1;
				lane_c[2] = n12p21_s1;
			end
			default: begin
				arg_c     = argz_s1;
				lane_c[0] = n10m01_s1;
				lane_c[1] = n02p20_s1;
				lane_c[2] = n12p21_s1;
			end
		endcase
		inv_c          = arg_c[rmq_pkg::ARG_W-1] || (arg_c == '0);
		side_c.sel     = sel_c;
		side_c.invalid = inv_c;
		for (int l = 0; l < rmq_pkg::N_LANE; l++) begin
			side_c.neg[l] = lane_c[l][rmq_pkg::NUM_W-1];
			side_c.mag[l] = lane_c[l][rmq_pkg::NUM_W-1] ? unsigned'(-lane_c[l])
			                                            : unsigned'(lane_c[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= inv_c ? '0 : rmq_pkg::SQ_W'({arg_c[rmq_pkg::ARG_W-2:0],
			                                        {rmq_pkg::FRAC_BITS{1'b0}}});
			side_s2 <= side_c;
		end
	end

	rmq_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_x     (x_s2),
		.in_side  (side_s2),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	rmq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sq_vld),
		.in_root  (sq_root),
		.in_side  (sq_side),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	always_comb begin
		for (int l = 0; l < rmq_pkg::N_LANE; l++) begin
			lane_o[l] = rmq_pkg::sat_out(dv_side.neg[l], dv_quo[l]);
		end
		quar_o = rmq_pkg::sat_out(1'b0, rmq_pkg::DW'(dv_side.quarter));
		case (dv_side.sel)
			rmq_pkg::BR_TRACE: begin
				qw = quar_o;    qx = lane_o[0]; qy = lane_o[1]; qz = lane_o[2];
			end
			rmq_pkg::BR_X: begin
				qw = lane_o[0]; qx = quar_o;    qy = lane_o[1]; qz = lane_o[2];
			end
			rmq_pkg::BR_Y: begin
				qw = lane_o[0]; qx = lane_o[1]; qy = quar_o;    qz = lane_o[2];
			end
			default: begin
				qw = lane_o[0]; qx = lane_o[1]; qy = lane_o[2]; qz = quar_o;
			end
		endcase
		if (dv_side.invalid) begin
			qw = '0;
			qx = '0;
			qy = '0;
			qz = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= rmq_pkg::OUT_DATA_W'({qz, qy, qx, qw});
			m_tuser <= {dv_side.invalid, dv_side.sel};
		end
	end

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata == '0)
		else $error("invalid beat carries nonzero quaternion");
	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] && (m_tuser[1:0] == rmq_pkg::BR_TRACE) |->
		!m_tdata[rmq_pkg::OUT_W-1])
		else $error("scalar part negative on the trace case");
`endif

endmodule

// ----- dv/tb_rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 1ps
// Testbench of the rotation matrix to quaternion pipeline: directed and random matrices
// with random stalls on both sides, checked against a fixed-point predictor.
// Depends on rmq_pkg and rotation_matrix_to_quaternion.
module tb_rotation_matrix_to_quaternion;

	typedef struct packed {
		logic [17:0] w;
		logic [17:0] x;
		logic [17:0] y;
		logic [17:0] z;
		logic [1:0]  br;
		logic        inv;
	} quat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [rmq_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [rmq_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [rmq_pkg::USER_W-1:0] m_tuser;

	quat_t pending_quats[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	bit calm = 1'b0;
	int branch_hits[4];
	int invalid_hits = 0;

	always #4 clk = ~clk;

	rotation_matrix_to_quaternion u_top (.*);

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [17:0] clamp18(input longint v);
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return v[17:0];
	endfunction

	function automatic longint quot_by_s(input longint num, input longint r);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag << rmq_pkg::FRAC_BITS) / (2 * r);
		return (num < 0) ? -q : q;
	endfunction

	function automatic quat_t predict_quat(input logic [rmq_pkg::IN_DATA_W-1:0] d);
		longint a[9];
		longint tr;
		longint arg;
		longint r;
		longint q;
		quat_t res;
		for (int i = 0; i < 9; i++) a[i] = longint'($signed(d[i*18 +: 18]));
		tr = a[0] + a[4] + a[8];
		if (tr > 0) begin
			res.br = rmq_pkg::BR_TRACE;
			arg = (64'sd1 << rmq_pkg::FRAC_BITS) + tr;
		end else if (a[0] > a[4] && a[0] > a[8]) begin
			res.br = rmq_pkg::BR_X;
			arg = (64'sd1 << rmq_pkg::FRAC_BITS) + a[0] - a[4] - a[8];
		end else if (a[4] > a[8]) begin
			res.br = rmq_pkg::BR_Y;
			arg = (64'sd1 << rmq_pkg::FRAC_BITS) + a[4] - a[0] - a[8];
		end else begin
			res.br = rmq_pkg::BR_Z;
			arg = (64'sd1 << rmq_pkg::FRAC_BITS) + a[8] - a[0] - a[4];
		end
		res.w = '0;
		res.x = '0;
		res.y = '0;
		res.z = '0;
		res.inv = 1'b1;
		if (arg > 0) begin
			res.inv = 1'b0;
			r = longint'(int_sqrt(64'(arg) << rmq_pkg::FRAC_BITS));
			q = r >> 1;
			case (res.br)
				rmq_pkg::BR_TRACE: begin
					res.w = clamp18(q);
					res.x = clamp18(quot_by_s(a[7] - a[5], r));
					res.y = clamp18(quot_by_s(a[2] - a[6], r));
					res.z = clamp18(quot_by_s(a[3] - a[1], r));
				end
				rmq_pkg::BR_X: begin
					res.w = clamp18(quot_by_s(a[7] - a[5], r));
					res.x = clamp18(q);
					res.y = clamp18(quot_by_s(a[1] + a[3], r));
					res.z = clamp18(quot_by_s(a[2] + a[6], r));
				end
				rmq_pkg::BR_Y: begin
					res.w = clamp18(quot_by_s(a[2] - a[6], r));
					res.x = clamp18(quot_by_s(a[1] + a[3], r));
					res.y = clamp18(q);
					res.z = clamp18(quot_by_s(a[5] + a[7], r));
				end
				default: begin
					res.w = clamp18(quot_by_s(a[3] - a[1], r));
					res.x = clamp18(quot_by_s(a[2] + a[6], r));
					res.y = clamp18(quot_by_s(a[5] + a[7], r));
					res.z = clamp18(q);
				end
			endcase
		end
		return res;
	endfunction

	task automatic send_matrix(input logic signed [17:0] m[9]);
		logic [rmq_pkg::IN_DATA_W-1:0] d;
		int gap;
		d = '0;
		for (int i = 0; i < 9; i++) d[i*18 +: 18] = m[i];
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_quats.push_back(predict_quat(d));
		sent++;
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
	endtask

	function automatic logic signed [17:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 18'sh1FFFF;
			1: return -18'sh20000;
			2: return 18'(($urandom_range(0, 131072) - 65536));
			default: return 18'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		quat_t got;
		quat_t exp_q;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[17:0], m_tdata[35:18], m_tdata[53:36], m_tdata[71:54],
				m_tuser[1:0], m_tuser[2]};
			received++;
			if (pending_quats.size() == 0) begin
				$error("result beat with no expectation: %h %h", m_tdata, m_tuser);
				errors++;
			end else begin
				exp_q = pending_quats.pop_front();
				branch_hits[got.br]++;
				if (got.inv) invalid_hits++;
				if (got.w !== exp_q.w) begin
					$error("quat_w expected %h actual %h", exp_q.w, got.w);
					errors++;
				end
				if (got.x !== exp_q.x) begin
					$error("quat_x expected %h actual %h", exp_q.x, got.x);
					errors++;
				end
				if (got.y !== exp_q.y) begin
					$error("quat_y expected %h actual %h", exp_q.y, got.y);
					errors++;
				end
				if (got.z !== exp_q.z) begin
					$error("quat_z expected %h actual %h", exp_q.z, got.z);
					errors++;
				end
				if (got.br !== exp_q.br) begin
					$error("branch_used expected %0d actual %0d", exp_q.br, got.br);
					errors++;
				end
				if (got.inv !== exp_q.inv) begin
					$error("invalid expected %0d actual %0d", exp_q.inv, got.inv);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (calm) begin
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 19);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic test_directed();
		logic signed [17:0] m[9];
		m = '{18'sd65536, 0, 0, 0, 18'sd65536, 0, 0, 0, 18'sd65536};
		send_matrix(m);
		m = '{18'sd65536, 0, 0, 0, -18'sd65536, 0, 0, 0, -18'sd65536};
		send_matrix(m);
		m = '{-18'sd65536, 0, 0, 0, 18'sd65536, 0, 0, 0, -18'sd65536};
		send_matrix(m);
		m = '{-18'sd65536, 0, 0, 0, -18'sd65536, 0, 0, 0, 18'sd65536};
		send_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(m);
		m = '{-18'sd40000, 5, 6, 7, -18'sd40000, 8, 9, 10, -18'sd40000};
		send_matrix(m);
		m = '{-18'sd131072, 0, 0, 0, -18'sd131072, 0, 0, 0, 18'sd131071};
		send_matrix(m);
		m = '{-18'sd131072, 0, 0, 0, 18'sd131071, 0, 0, 0, 18'sd131071};
		send_matrix(m);
		m = '{-18'sd131072, 0, 0, 0, -18'sd131072, 0, 0, 0, -18'sd131072};
		send_matrix(m);
		m = '{18'sd1, 18'sd131071, -18'sd131072, -18'sd131072, 0, 18'sd131071,
			18'sd131071, -18'sd131072, 0};
		send_matrix(m);
		m = '{-18'sd70000, 18'sd131071, 18'sd131071, 18'sd131071, -18'sd70000,
			18'sd131071, 18'sd131071, 18'sd131071, 0};
		send_matrix(m);
		m = '{-18'sd65536, -18'sd131072, -18'sd131072, -18'sd131072, -18'sd65536,
			-18'sd131072, -18'sd131072, -18'sd131072, 18'sd131071};
		send_matrix(m);
		m = '{18'sd131071, 18'sd131071, 18'sd131071, 18'sd131071, 18'sd131071,
			18'sd131071, 18'sd131071, 18'sd131071, 18'sd131071};
		send_matrix(m);
		m = '{-18'sd1, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(m);
		stop_sending();
	endtask

	task automatic test_random(input int count);
		logic signed [17:0] m[9];
		for (int k = 0; k < count; k++) begin
			for (int i = 0; i < 9; i++) m[i] = rand_elem();
			if ($urandom_range(0, 2) == 0) begin
				m[0] = -m[4];
				m[8] = 18'($urandom_range(0, 3)) - 18'sd2;
			end
			send_matrix(m);
		end
		stop_sending();
	endtask

	task automatic drain();
		while (pending_quats.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400);
		calm = 1'b1;
		test_random(100);
		drain();
		$display("Sent %0d matrices, got %0d quaternions.", sent, received);
		$display("Branches %0d/%0d/%0d/%0d, invalid %0d.",
			branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3],
			invalid_hits);
		if (errors == 0 && pending_quats.size() == 0) begin
			$display("[rotation_matrix_to_quaternion] OK");
		end else begin
			$display("[rotation_matrix_to_quaternion] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[rotation_matrix_to_quaternion] ERROR");
		$finish;
	end

endmodule

// ----- rotation_matrix_to_quaternion.f -----
hdl/rmq_pkg.sv
hdl/rmq_sqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion.sv
dv/tb_rotation_matrix_to_quaternion.sv
